// ===== sv/gm_pkg.sv =====
// Shared types, S-box table and round helpers for the Magma block cipher.
package gm_pkg;

  localparam int ROUNDS      = 32;
  localparam int KEY_COUNT   = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int ROT_AMOUNT  = 11;
  // first round of the reversed key order, per direction
  localparam int ENC_REV_START = 24;
  localparam int DEC_REV_START = 8;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef logic [KEY_COUNT-1:0][31:0] key_t;

  // one item in flight: direction plus the two Feistel halves
  typedef struct packed {
    logic        op;
    logic [31:0] n1;
    logic [31:0] n2;
  } stage_t;

  // configuration write beat
  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_wr_t;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'hF, 4'hC, 4'h2, 4'hA, 4'h6, 4'h4, 4'h5, 4'h0,
      4'h7, 4'h9, 4'hE, 4'hD, 4'h1, 4'hB, 4'h8, 4'h3},
    '{4'hB, 4'h6, 4'h3, 4'h4, 4'hC, 4'hF, 4'hE, 4'h2,
      4'h7, 4'hD, 4'h8, 4'h0, 4'h5, 4'hA, 4'h9, 4'h1},
    '{4'h1, 4'hC, 4'hB, 4'h0, 4'hF, 4'hE, 4'h6, 4'h5,
      4'hA, 4'hD, 4'h4, 4'h8, 4'h9, 4'h3, 4'h7, 4'h2},
    '{4'h1, 4'h5, 4'hE, 4'hC, 4'hA, 4'h7, 4'h0, 4'hD,
      4'h6, 4'h2, 4'hB, 4'h4, 4'h9, 4'h3, 4'hF, 4'h8},
    '{4'h0, 4'hC, 4'h8, 4'h9, 4'hD, 4'h2, 4'hA, 4'hB,
      4'h7, 4'h3, 4'h6, 4'h5, 4'h4, 4'hE, 4'hF, 4'h1},
    '{4'h8, 4'h0, 4'hF, 4'h3, 4'h2, 4'h5, 4'hE, 4'hB,
      4'h1, 4'hA, 4'h4, 4'h7, 4'hC, 4'h9, 4'hD, 4'h6},
    '{4'h3, 4'h0, 4'h6, 4'hF, 4'h1, 4'hE, 4'h9, 4'h2,
      4'hD, 4'h8, 4'hC, 4'h4, 4'hB, 4'hA, 4'h5, 4'h7},
    '{4'h1, 4'hA, 4'h6, 4'h8, 4'hF, 4'hB, 4'h0, 4'h4,
      4'hC, 4'h3, 4'h5, 4'h9, 4'h7, 4'hD, 4'h2, 4'hE}
  };

  // key word used by round r for the given direction
  function automatic logic [2:0] key_index(input int r, input logic op);
    logic [2:0] rl;
    int         rev_start;
    rl        = 3'(r % KEY_COUNT);
    rev_start = (op == OP_DECRYPT) ? DEC_REV_START : ENC_REV_START;
    return (r < rev_start) ? rl : (3'(KEY_COUNT - 1) - rl);
  endfunction

  // nibble-wise substitution through S-box row
  function automatic logic [31:0] subst(input logic [31:0] x, input logic [2:0] row);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = SBOX[row][x[4*i +: 4]];
    end
    return r;
  endfunction

  // rotate left by the round rotation amount
  function automatic logic [31:0] rotl(input logic [31:0] x);
    return {x[31-ROT_AMOUNT:0], x[31:32-ROT_AMOUNT]};
  endfunction

endpackage

// ===== sv/gm_key_regs.sv =====
// Round-key register file, written through the configuration port.
module gm_key_regs (
  input  logic           clk,
  input  logic           rst,
  input  gm_pkg::cfg_wr_t cfg,
  output gm_pkg::key_t   keys
);

  // indexes past the last key word are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (cfg.valid &&
                 (cfg.index < gm_pkg::CFG_IDX_W'(gm_pkg::KEY_COUNT))) begin
      keys[cfg.index[2:0]] <= cfg.data;
    end
  end

endmodule

// ===== sv/gm_round.sv =====
// One Feistel round as a pipeline stage with its own valid/ready.
module gm_round #(
  parameter int ROUND = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  gm_pkg::key_t   keys,
  input  logic           in_valid,
  output logic           in_ready,
  input  gm_pkg::stage_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output gm_pkg::stage_t out_data
);

  logic [2:0]     kidx;
  logic [31:0]    sum;
  logic [31:0]    f;
  gm_pkg::stage_t res;

  // round function: add key, substitute, rotate, mix into other half
  always_comb begin
    kidx    = gm_pkg::key_index(ROUND, in_data.op);
    sum     = in_data.n1 + keys[kidx];
    f       = gm_pkg::rotl(gm_pkg::subst(sum, kidx));
    res.op  = in_data.op;
    res.n1  = f ^ in_data.n2;
    res.n2  = in_data.n1;
  end

  // stage takes a beat when empty or when its beat moves on
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res;
    end
  end

endmodule

// ===== sv/gost_magma_block_cipher.sv =====
// Top level of the pipelined Magma (GOST 28147-89) block cipher.
// Each of the 32 rounds is one register stage, so a 64-bit block can enter every
// cycle unless back-pressure from out_ready holds the pipeline, and leaves once
// it has passed through all 32 round registers. Stages hold valid bits and a
// per-stage ready, so a stalled output keeps its beat while bubbles further
// up still fill. Key words are written over the cfg port (index 0..7, others
// ignored) and must only be changed while no block is in flight.
module gost_magma_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [63:0] block_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] block_out
);

  gm_pkg::cfg_wr_t cfg;
  gm_pkg::key_t    keys;

  gm_pkg::stage_t  sdata [gm_pkg::ROUNDS+1];
  logic            svalid [gm_pkg::ROUNDS+1];
  logic            sready [gm_pkg::ROUNDS+1];

  // key registers
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  gm_key_regs u_keys (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .keys (keys)
  );

  // input beat into the first round
  assign svalid[0]   = in_valid;
  assign sdata[0].op = op;
  assign sdata[0].n1 = block_in[63:32];
  assign sdata[0].n2 = block_in[31:0];
  assign in_ready    = sready[0];

  // round pipeline
  for (genvar r = 0; r < gm_pkg::ROUNDS; r++) begin : g_round
    gm_round #(.ROUND(r)) u_round (
      .clk       (clk),
      .rst       (rst),
      .keys      (keys),
      .in_valid  (svalid[r]),
      .in_ready  (sready[r]),
      .in_data   (sdata[r]),
      .out_valid (svalid[r+1]),
      .out_ready (sready[r+1]),
      .out_data  (sdata[r+1])
    );
  end

  // output: final halves swapped, N2 high
  assign out_valid                = svalid[gm_pkg::ROUNDS];
  assign sready[gm_pkg::ROUNDS]   = out_ready;
  assign block_out = {sdata[gm_pkg::ROUNDS].n2, sdata[gm_pkg::ROUNDS].n1};

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the pipelined Magma block cipher: directed and random blocks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_TAIL     = 40;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_BLOCKS   = 150;
  localparam int MAX_REPORTS    = 50;
  // rounds run with the key words in forward order before switching to reverse
  localparam int ENC_FWD_ROUNDS = 24;
  localparam int DEC_FWD_ROUNDS = 8;

  // substitution rows, one per key index
  localparam logic [3:0] MAGMA_SBOX [8][16] = '{
    '{4'hF, 4'hC, 4'h2, 4'hA, 4'h6, 4'h4, 4'h5, 4'h0,
      4'h7, 4'h9, 4'hE, 4'hD, 4'h1, 4'hB, 4'h8, 4'h3},
    '{4'hB, 4'h6, 4'h3, 4'h4, 4'hC, 4'hF, 4'hE, 4'h2,
      4'h7, 4'hD, 4'h8, 4'h0, 4'h5, 4'hA, 4'h9, 4'h1},
    '{4'h1, 4'hC, 4'hB, 4'h0, 4'hF, 4'hE, 4'h6, 4'h5,
      4'hA, 4'hD, 4'h4, 4'h8, 4'h9, 4'h3, 4'h7, 4'h2},
    '{4'h1, 4'h5, 4'hE, 4'hC, 4'hA, 4'h7, 4'h0, 4'hD,
      4'h6, 4'h2, 4'hB, 4'h4, 4'h9, 4'h3, 4'hF, 4'h8},
    '{4'h0, 4'hC, 4'h8, 4'h9, 4'hD, 4'h2, 4'hA, 4'hB,
      4'h7, 4'h3, 4'h6, 4'h5, 4'h4, 4'hE, 4'hF, 4'h1},
    '{4'h8, 4'h0, 4'hF, 4'h3, 4'h2, 4'h5, 4'hE, 4'hB,
      4'h1, 4'hA, 4'h4, 4'h7, 4'hC, 4'h9, 4'hD, 4'h6},
    '{4'h3, 4'h0, 4'h6, 4'hF, 4'h1, 4'hE, 4'h9, 4'h2,
      4'hD, 4'h8, 4'hC, 4'h4, 4'hB, 4'hA, 4'h5, 4'h7},
    '{4'h1, 4'hA, 4'h6, 4'h8, 4'hF, 4'hB, 4'h0, 4'h4,
      4'hC, 4'h3, 4'h5, 4'h9, 4'h7, 4'hD, 4'h2, 4'hE}
  };

  typedef struct {
    logic        op;
    logic [63:0] block_in;
    logic [63:0] block_out;
  } cipher_expect_t;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [gm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                  cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic                         op        = 1'b0;
  logic [63:0]                  block_in  = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [63:0]                  block_out;

  gm_pkg::key_t   key_model = '0;
  cipher_expect_t cipher_q [$];

  bit src_idle_en  = 1'b0;
  bit sink_idle_en = 1'b0;
  int stall_left   = 0;
  int idle_cycles  = 0;

  int error_count     = 0;
  int blocks_sent     = 0;
  int decrypt_count   = 0;
  int results_checked = 0;
  int key_writes      = 0;
  int key_settings    = 0;

  gost_magma_block_cipher DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .block_in  (block_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .block_out (block_out)
  );

  always #1 clk = ~clk;

  // 32-round Feistel network, N1 high half, N2 low half, output {N2, N1}
  function automatic logic [63:0] magma_transform(input logic dir, input logic [63:0] blk,
                                                  input gm_pkg::key_t keys);
    logic [31:0] n1, n2, sum, sub, f;
    logic [2:0]  ksel;
    n1 = blk[63:32];
    n2 = blk[31:0];
    for (int r = 0; r < gm_pkg::ROUNDS; r++) begin
      ksel = 3'(r);
      // reverse order: 7 - k is the bitwise inverse of a 3-bit index
      if ((dir == gm_pkg::OP_ENCRYPT && r >= ENC_FWD_ROUNDS) ||
          (dir == gm_pkg::OP_DECRYPT && r >= DEC_FWD_ROUNDS)) begin
        ksel = ~ksel;
      end
      sum = n1 + keys[ksel];
      for (int i = 0; i < 8; i++) begin
        sub[4*i +: 4] = MAGMA_SBOX[ksel][sum[4*i +: 4]];
      end
      f  = {sub[20:0], sub[31:21]} ^ n2;
      n2 = n1;
      n1 = f;
    end
    return {n2, n1};
  endfunction

  // idle stretch length: mostly short, a few long
  function automatic int pick_stall();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_block();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return 64'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // kind 0: all ones, 1: alternating zero/ones words, 2: near 2^32 (carries), else random
  function automatic gm_pkg::key_t rand_key(input int kind);
    gm_pkg::key_t k;
    for (int i = 0; i < gm_pkg::KEY_COUNT; i++) begin
      case (kind)
        0: k[i] = 32'hFFFF_FFFF;
        1: k[i] = (i % 2) ? 32'hFFFF_FFFF : 32'h0;
        2: k[i] = 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
        default: k[i] = $urandom;
      endcase
    end
    return k;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // one key register write beat; called at a rising edge, returns at one
  task automatic write_key(input logic [gm_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < gm_pkg::KEY_COUNT) key_model[idx[2:0]] = val;
    key_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key(input gm_pkg::key_t k);
    for (int i = 0; i < gm_pkg::KEY_COUNT; i++) write_key(gm_pkg::CFG_IDX_W'(i), k[i]);
    key_settings++;
  endtask

  // one input beat; valid stays high into the next call when no gap is drawn
  task automatic send_block(input logic dir, input logic [63:0] blk);
    cipher_expect_t e;
    int             gap;
    in_valid <= 1'b1;
    op       <= dir;
    block_in <= blk;
    do @(posedge clk); while (!in_ready);
    e.op        = dir;
    e.block_in  = blk;
    e.block_out = magma_transform(dir, blk, key_model);
    cipher_q.push_back(e);
    blocks_sent++;
    if (dir == gm_pkg::OP_DECRYPT) decrypt_count++;
    gap = (src_idle_en && $urandom_range(0, 99) < 35) ? pick_stall() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every block in flight to come out
  task automatic drain();
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // reset key (all zero) with extreme blocks in both directions
  task automatic test_zero_key_extremes();
    logic [63:0] pats [6] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
                              64'h5555_5555_5555_5555, 64'h8000_0000_0000_0000, 64'h1};
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    foreach (pats[i]) begin
      send_block(gm_pkg::OP_ENCRYPT, pats[i]);
      send_block(gm_pkg::OP_DECRYPT, pats[i]);
    end
    drain();
  endtask

  // all-ones key, writes to indexes past the key array, alternating key words
  task automatic test_key_register_writes();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    load_key(rand_key(0));
    send_block(gm_pkg::OP_ENCRYPT, 64'h0);
    send_block(gm_pkg::OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(gm_pkg::OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
    drain();
    // out-of-range indexes must be ignored by the key store
    for (int i = gm_pkg::KEY_COUNT; i < 2**gm_pkg::CFG_IDX_W; i++) begin
      write_key(gm_pkg::CFG_IDX_W'(i), (i % 2) ? 32'h0 : 32'h1234_5678 ^ $urandom);
    end
    send_block(gm_pkg::OP_DECRYPT, 64'h0);
    send_block(gm_pkg::OP_ENCRYPT, 64'hFEDC_BA98_7654_3210);
    drain();
    load_key(rand_key(1));
    send_block(gm_pkg::OP_ENCRYPT, 64'hFFFF_FFFF_0000_0000);
    send_block(gm_pkg::OP_DECRYPT, 64'h0000_0000_FFFF_FFFF);
    drain();
  endtask

  // encrypt a block, then decrypt its ciphertext back to the plaintext
  task automatic test_round_trip();
    logic [63:0] plain, cipher;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b1;
    load_key(rand_key(3));
    for (int i = 0; i < 4; i++) begin
      plain  = rand_block();
      cipher = magma_transform(gm_pkg::OP_ENCRYPT, plain, key_model);
      if (magma_transform(gm_pkg::OP_DECRYPT, cipher, key_model) !== plain) begin
        report_mismatch($sformatf("round trip of %h does not restore it", plain));
      end
      send_block(gm_pkg::OP_ENCRYPT, plain);
      send_block(gm_pkg::OP_DECRYPT, cipher);
    end
    drain();
  endtask

  // phases of random blocks, a new key per phase, idling modes rotated
  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_key(rand_key(p < 3 ? p : 3));
      src_idle_en  = (p % 3 != 0);
      sink_idle_en = (p % 3 != 1);
      repeat (PHASE_BLOCKS) send_block(1'($urandom_range(0, 1)), rand_block());
      drain();
    end
  endtask

  // receiver: random stalls on out_ready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 99) < 15) begin
      stall_left <= pick_stall() - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each output beat with the oldest expected block
  always @(posedge clk) begin : check_results
    cipher_expect_t e;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (cipher_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no block in flight", block_out));
      end else begin
        e = cipher_q.pop_front();
        if (block_out !== e.block_out) begin
          report_mismatch($sformatf("%s of %h: got %h, expected %h",
                                    (e.op == gm_pkg::OP_DECRYPT) ? "decrypt" : "encrypt",
                                    e.block_in, block_out, e.block_out));
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles, %0d blocks in flight",
                 $realtime, idle_cycles, cipher_q.size());
        $display("gost_magma_block_cipher test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_zero_key_extremes();
    test_key_register_writes();
    test_round_trip();
    test_random_traffic();
    $display("Covered %0d blocks (%0d decrypt), %0d results checked, %0d mismatches.",
             blocks_sent, decrypt_count, results_checked, error_count);
    $display("Key store: %0d register writes across %0d full key loads, stalls on both sides.",
             key_writes, key_settings);
    if (error_count == 0) begin
      $display("gost_magma_block_cipher test passed");
    end else begin
      $display("gost_magma_block_cipher test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/gm_pkg.sv
sv/gm_key_regs.sv
sv/gm_round.sv
sv/gost_magma_block_cipher.sv
test/testbench.sv
